>>> hw/rtl/dqe_pkg.sv
// Package for the deque engine: operation codes, status codes, item types, defaults.
`default_nettype none
package dqe_pkg;

  localparam int unsigned DefDepth = 1024;
  localparam int unsigned DefWidth = 32;

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_BACK  = 3'd5,
    FN_SIZE       = 3'd6,
    FN_CLEAR      = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_VALUE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  typedef struct packed {
    func_e              func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] result;
  } rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/deque_engine_unit.sv
// Deque engine top level: circular buffer deque with pointer and count registers.
// Push, size, clear and any error give done_o in the cycle after start.
// Pop and peek read the buffer RAM (registered read) and give done_o in the cycle
// after start as well, but hold busy high for that cycle, so no new item is taken then.
// Non-reading operations take one item per cycle; a read blocks the next item while busy.
// Reset clears pointers, count and control; buffer contents stay undefined.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none
module deque_engine_unit #(
  parameter int unsigned DEPTH = dqe_pkg::DefDepth,
  parameter int unsigned WIDTH = dqe_pkg::DefWidth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire dqe_pkg::req_t req_i,
  output logic               done_o,
  output dqe_pkg::rsp_t      rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  dqe_pkg::state_e state_q, state_d;
  logic [AW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]   count_q, count_d;
  logic            done_q, done_d;
  dqe_pkg::rsp_t   rsp_q, rsp_d;

  logic             accept, is_read, empty, full;
  logic [AW-1:0]    head_dec, head_inc, tail_dec, tail_inc;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [WIDTH-1:0] ram_wdata, ram_rdata;

  assign accept   = start && !busy;
  assign empty    = (count_q == '0);
  assign full     = (count_q == FullCnt);
  assign head_dec = (head_q == '0) ? LastIdx : head_q - AW'(1);
  assign head_inc = (head_q == LastIdx) ? '0 : head_q + AW'(1);
  assign tail_dec = (tail_q == '0) ? LastIdx : tail_q - AW'(1);
  assign tail_inc = (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
  assign is_read  = !empty && (req_i.func inside {dqe_pkg::FN_POP_FRONT,
                                                  dqe_pkg::FN_POP_BACK,
                                                  dqe_pkg::FN_PEEK_FRONT,
                                                  dqe_pkg::FN_PEEK_BACK});
  assign ram_wdata = WIDTH'($unsigned(req_i.value));

  // Datapath: pointer/count update, RAM access, registered result.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    done_d   = 1'b0;
    rsp_d    = '{status: dqe_pkg::ST_OK, result: '0};
    ram_we   = 1'b0;
    ram_addr = head_q;
    if (accept) begin
      done_d = !is_read;
      case (req_i.func)
        dqe_pkg::FN_PUSH_FRONT: begin
          if (full) begin
            rsp_d.status = dqe_pkg::ST_FULL;
          end else begin
            head_d   = head_dec;
            ram_addr = head_dec;
            ram_we   = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        dqe_pkg::FN_PUSH_BACK: begin
          if (full) begin
            rsp_d.status = dqe_pkg::ST_FULL;
          end else begin
            tail_d   = tail_inc;
            ram_addr = tail_q;
            ram_we   = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        dqe_pkg::FN_POP_FRONT, dqe_pkg::FN_PEEK_FRONT: begin
          if (empty) begin
            rsp_d.status = dqe_pkg::ST_EMPTY;
          end else begin
            ram_addr = head_q;
            if (req_i.func == dqe_pkg::FN_POP_FRONT) begin
              head_d  = head_inc;
              count_d = count_q - CW'(1);
            end
          end
        end
        dqe_pkg::FN_POP_BACK, dqe_pkg::FN_PEEK_BACK: begin
          if (empty) begin
            rsp_d.status = dqe_pkg::ST_EMPTY;
          end else begin
            ram_addr = tail_dec;
            if (req_i.func == dqe_pkg::FN_POP_BACK) begin
              tail_d  = tail_dec;
              count_d = count_q - CW'(1);
            end
          end
        end
        dqe_pkg::FN_SIZE: begin
          rsp_d.status = dqe_pkg::ST_VALUE;
          rsp_d.result = 32'($unsigned(count_q));
        end
        dqe_pkg::FN_CLEAR: begin
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
        end
        default: begin
          rsp_d.status = dqe_pkg::ST_OK;
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dqe_pkg::S_IDLE: begin
        if (accept && is_read) state_d = dqe_pkg::S_READ;
      end
      dqe_pkg::S_READ: begin
        state_d = dqe_pkg::S_IDLE;
      end
      default: begin
        state_d = dqe_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    busy   = 1'b0;
    done_o = done_q;
    rsp_o  = rsp_q;
    case (state_q)
      dqe_pkg::S_READ: begin
        busy         = 1'b1;
        done_o       = 1'b1;
        rsp_o.status = dqe_pkg::ST_VALUE;
        rsp_o.result = 32'(signed'(ram_rdata));
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dqe_pkg::S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  dqe_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("count exceeds depth");

  a_read_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dqe_pkg::S_READ) |-> !done_q)
    else $error("registered result pending during read");

  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result without accepted item");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !empty && req_i.func == dqe_pkg::FN_POP_FRONT)
      |=> count_q == $past(count_q) - CW'(1))
    else $error("pop did not decrement count");

endmodule
`default_nettype wire

>>> hw/rtl/dqe_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module dqe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

>>> sim/deque_engine_unit_test.sv
// Testbench for deque_engine_unit: directed and random queue operations checked against a predictor.
`timescale 1ns / 1ps
module deque_engine_unit_test;

  localparam int unsigned DEPTH = dqe_pkg::DefDepth;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  dqe_pkg::req_t  req_i = '0;
  logic           done_o;
  dqe_pkg::rsp_t  rsp_o;

  deque_engine_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow deque
  logic [31:0] dq_mem [DEPTH];
  int unsigned dq_head = 0;
  int unsigned dq_tail = 0;
  int unsigned dq_count = 0;

  dqe_pkg::rsp_t exp_rsp_q [$];
  int unsigned   err_cnt = 0;
  int unsigned   cycle_cnt = 0;
  bit            idle_en = 1'b1;

  function automatic int unsigned ptr_next(int unsigned p);
    return (p == DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic int unsigned ptr_prev(int unsigned p);
    return (p == 0) ? DEPTH - 1 : p - 1;
  endfunction

  function automatic dqe_pkg::rsp_t deque_apply(dqe_pkg::req_t r);
    dqe_pkg::rsp_t rsp;
    int unsigned   idx;
    rsp = '{status: dqe_pkg::ST_OK, result: '0};
    case (r.func)
      dqe_pkg::FN_PUSH_FRONT, dqe_pkg::FN_PUSH_BACK: begin
        if (dq_count >= DEPTH) begin
          rsp.status = dqe_pkg::ST_FULL;
        end else begin
          if (r.func == dqe_pkg::FN_PUSH_FRONT) begin
            dq_head = ptr_prev(dq_head);
            dq_mem[dq_head] = r.value;
          end else begin
            dq_mem[dq_tail] = r.value;
            dq_tail = ptr_next(dq_tail);
          end
          dq_count++;
        end
      end
      dqe_pkg::FN_POP_FRONT, dqe_pkg::FN_POP_BACK,
      dqe_pkg::FN_PEEK_FRONT, dqe_pkg::FN_PEEK_BACK: begin
        if (dq_count == 0) begin
          rsp.status = dqe_pkg::ST_EMPTY;
        end else begin
          idx = (r.func == dqe_pkg::FN_POP_FRONT || r.func == dqe_pkg::FN_PEEK_FRONT)
                ? dq_head : ptr_prev(dq_tail);
          rsp.status = dqe_pkg::ST_VALUE;
          rsp.result = dq_mem[idx];
          if (r.func == dqe_pkg::FN_POP_FRONT) begin
            dq_head = ptr_next(dq_head);
            dq_count--;
          end else if (r.func == dqe_pkg::FN_POP_BACK) begin
            dq_tail = idx;
            dq_count--;
          end
        end
      end
      dqe_pkg::FN_SIZE: begin
        rsp.status = dqe_pkg::ST_VALUE;
        rsp.result = 32'(dq_count);
      end
      default: begin
        dq_head = 0;
        dq_tail = 0;
        dq_count = 0;
      end
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic idle_burst(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  task automatic send_item(dqe_pkg::func_e f, logic signed [31:0] v);
    dqe_pkg::req_t r;
    r.func = f;
    r.value = v;
    if (idle_en && $urandom_range(0, 5) == 0) idle_burst($urandom_range(1, 19));
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
    exp_rsp_q.insert(exp_rsp_q.size(), deque_apply(r));
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic dqe_pkg::func_e rand_func(int unsigned push_pct);
    int unsigned r;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? dqe_pkg::FN_PUSH_BACK : dqe_pkg::FN_PUSH_FRONT;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 1) ? dqe_pkg::FN_POP_BACK : dqe_pkg::FN_POP_FRONT;
    if (r < 80) return $urandom_range(0, 1) ? dqe_pkg::FN_PEEK_BACK : dqe_pkg::FN_PEEK_FRONT;
    if (r < 97) return dqe_pkg::FN_SIZE;
    return dqe_pkg::FN_CLEAR;
  endfunction

  always @(posedge clk_i) begin
    dqe_pkg::rsp_t exp;
    if (rst_ni && done_o) begin
      if (exp_rsp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d result=%0d",
                                  rsp_o.status, rsp_o.result));
      end else begin
        exp = exp_rsp_q[0];
        exp_rsp_q.delete(0);
        if (rsp_o.status !== exp.status)
          report_mismatch($sformatf("status %0d, expected %0d", rsp_o.status, exp.status));
        if (rsp_o.result !== exp.result)
          report_mismatch($sformatf("result %0h, expected %0h", rsp_o.result, exp.result));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_empty_queue();
    send_item(dqe_pkg::FN_POP_FRONT, 32'sd5);
    send_item(dqe_pkg::FN_POP_BACK, -32'sd1);
    send_item(dqe_pkg::FN_PEEK_FRONT, 32'sd0);
    send_item(dqe_pkg::FN_PEEK_BACK, 32'sh7fff_ffff);
    send_item(dqe_pkg::FN_SIZE, 32'sh8000_0000);
    send_item(dqe_pkg::FN_CLEAR, -32'sd1);
  endtask

  task automatic test_word_extremes();
    send_item(dqe_pkg::FN_PUSH_FRONT, 32'sh8000_0000);
    send_item(dqe_pkg::FN_PUSH_BACK, 32'sh7fff_ffff);
    send_item(dqe_pkg::FN_PUSH_FRONT, -32'sd1);
    send_item(dqe_pkg::FN_PUSH_BACK, 32'sd0);
    send_item(dqe_pkg::FN_PEEK_FRONT, 32'sd0);
    send_item(dqe_pkg::FN_PEEK_BACK, 32'sd0);
    send_item(dqe_pkg::FN_SIZE, 32'sd0);
    send_item(dqe_pkg::FN_POP_FRONT, 32'sd0);
    send_item(dqe_pkg::FN_POP_BACK, 32'sd0);
    send_item(dqe_pkg::FN_POP_FRONT, 32'sd0);
    send_item(dqe_pkg::FN_CLEAR, 32'sd0);
    send_item(dqe_pkg::FN_POP_BACK, 32'sd0);
    send_item(dqe_pkg::FN_SIZE, 32'sd0);
    send_item(dqe_pkg::FN_PUSH_BACK, 32'sh5555_aaaa);
    send_item(dqe_pkg::FN_POP_BACK, 32'sd0);
  endtask

  // fill to capacity from both ends, overflow both ends, then drain part of it
  task automatic test_full_and_wrap();
    send_item(dqe_pkg::FN_CLEAR, 32'sd0);
    repeat (DEPTH)
      send_item($urandom_range(0, 1) ? dqe_pkg::FN_PUSH_BACK : dqe_pkg::FN_PUSH_FRONT,
                rand_word());
    send_item(dqe_pkg::FN_PUSH_FRONT, 32'sh1234_5678);
    send_item(dqe_pkg::FN_PUSH_BACK, -32'sd1);
    send_item(dqe_pkg::FN_SIZE, 32'sd0);
    send_item(dqe_pkg::FN_PEEK_FRONT, 32'sd0);
    send_item(dqe_pkg::FN_PEEK_BACK, 32'sd0);
    send_item(dqe_pkg::FN_POP_BACK, 32'sd0);
    send_item(dqe_pkg::FN_PUSH_BACK, 32'sh7fff_ffff);
    send_item(dqe_pkg::FN_PUSH_FRONT, 32'sh8000_0000);
    repeat (96)
      send_item($urandom_range(0, 1) ? dqe_pkg::FN_POP_BACK : dqe_pkg::FN_POP_FRONT,
                $urandom);
    send_item(dqe_pkg::FN_POP_FRONT, 32'sd0);
    send_item(dqe_pkg::FN_SIZE, 32'sd0);
  endtask

  task automatic test_random_mix(int unsigned n, int unsigned push_pct);
    repeat (n) send_item(rand_func(push_pct), rand_word());
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_queue();
    test_word_extremes();
    test_full_and_wrap();
    test_random_mix(200, 60);
    test_random_mix(160, 35);
    idle_en = 1'b0;
    test_random_mix(200, 48);
    @(negedge clk_i);
    start = 1'b0;
    while (exp_rsp_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
